// ===== src/gckp_pkg.sv =====
// Shared types and constants for the grid cell key packer.
// Used by every module of the block; depends on nothing.
package gckp_pkg;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int SIDE_W    = 31;
    localparam int KEY_W     = 58;
    localparam int DVD_W     = 33;  // magnitude of 2c - s, one bit per divide step
    localparam int DVS_W     = SIDE_W + 1;  // divisor 2s
    localparam int NUM_W     = DVD_W + 1;   // signed 2c - s
    localparam int SNAP_W    = NUM_W;       // signed snapped coordinate
    localparam int DIGIT_W   = 18;
    localparam int CLAMP_W   = 17;
    localparam int XY_W      = 38;
    localparam int XY_SPLIT  = 19;
    localparam int CFG_IDX_W = 1;

    // Default fraction bits of the coordinates
    localparam int FRAC_BITS_DEF = 12;

    // Decimal packing constants
    localparam logic [CLAMP_W-1:0] MAG_LIMIT   = 17'd99999;
    localparam logic [DIGIT_W-1:0] SIGN_DIGIT  = 18'd100000;
    localparam logic [19:0]        AXIS_SCALE  = 20'd1000000;
    localparam logic [SIDE_W-1:0]  SIDE_RESET  = 31'd4096;

    // Pipeline depths
    localparam int LANE_LAT  = 1 + DVD_W + 2;
    localparam int MERGE_LAT = 2;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SNAP_ENABLE = 1'b0,
        REG_SIDE_LENGTH = 1'b1
    } cfg_reg_t;

    // Input word
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } point_t;

    // Result word
    typedef struct packed {
        logic [KEY_W-1:0] cell_key;
        logic             saturated;
    } key_word_t;

    // Grid configuration seen by the lanes
    typedef struct packed {
        logic              snap;
        logic [SIDE_W-1:0] side;
    } grid_cfg_t;

    // State carried through the divide steps
    typedef struct packed {
        logic [DVS_W-1:0]          rem;
        logic [DVD_W-1:0]          dvd;
        logic signed [COORD_W-1:0] coord;
        logic                      neg;
    } div_word_t;

endpackage

// ===== src/gckp_div_step.sv =====
// One restoring divide step: brings in one dividend bit and subtracts 2s.
// Depends on gckp_pkg.
module gckp_div_step (
    input  logic                  aclk,
    input  logic                  adv,
    input  gckp_pkg::grid_cfg_t   cfg,
    input  gckp_pkg::div_word_t   din,
    output gckp_pkg::div_word_t   dout_reg
);

    logic [gckp_pkg::DVS_W:0]   trial;
    logic [gckp_pkg::DVS_W:0]   dvs;
    logic [gckp_pkg::DVS_W:0]   diff;
    gckp_pkg::div_word_t        dout_next;

    // Shift in the next bit, subtract when it fits
    always_comb begin
        trial = {din.rem, din.dvd[gckp_pkg::DVD_W-1]};
        dvs   = {1'b0, cfg.side, 1'b0};
        diff  = trial - dvs;
        dout_next       = din;
        dout_next.dvd   = {din.dvd[gckp_pkg::DVD_W-2:0], 1'b0};
        dout_next.rem   = (trial >= dvs) ? diff[gckp_pkg::DVS_W-1:0]
                                         : trial[gckp_pkg::DVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dout_reg <= dout_next;
        end
    end

endmodule

// ===== src/gckp_lane.sv =====
// One axis lane: grid snap through a pipelined floor modulo, then decimal digits.
// Depends on gckp_pkg and gckp_div_step.
module gckp_lane #(
    parameter int FRAC_BITS = gckp_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 adv,
    input  gckp_pkg::grid_cfg_t                  cfg,
    input  logic signed [gckp_pkg::COORD_W-1:0]  coord,
    output logic [gckp_pkg::DIGIT_W-1:0]         digit_reg,
    output logic                                 sat_reg
);

    logic signed [gckp_pkg::NUM_W-1:0]   num;
    gckp_pkg::div_word_t                 word_next;
    gckp_pkg::div_word_t                 entry_reg;
    gckp_pkg::div_word_t                 chain [0:gckp_pkg::DVD_W];

    logic [gckp_pkg::DVS_W-1:0]          dvs;
    logic [gckp_pkg::DVS_W-1:0]          rmd;
    logic                                snap_on;
    logic signed [gckp_pkg::SNAP_W:0]    sum;
    logic signed [gckp_pkg::SNAP_W-1:0]  snap_next;
    logic signed [gckp_pkg::SNAP_W-1:0]  snap_reg;

    logic                                neg;
    logic [gckp_pkg::SNAP_W-1:0]         mag;
    logic [gckp_pkg::SNAP_W-1:0]         shifted;
    logic                                sat_next;
    logic [gckp_pkg::CLAMP_W-1:0]        clamped;
    logic [gckp_pkg::DIGIT_W-1:0]        digit_next;

    // Form 2c - s and fold a negative value to -n-1 for the unsigned divide
    always_comb begin
        num = $signed({coord[gckp_pkg::COORD_W-1], coord, 1'b0})
            - $signed({3'b000, cfg.side});
        word_next.rem   = '0;
        word_next.neg   = num[gckp_pkg::NUM_W-1];
        word_next.dvd   = num[gckp_pkg::NUM_W-1] ? ~num[gckp_pkg::DVD_W-1:0]
                                                 : num[gckp_pkg::DVD_W-1:0];
        word_next.coord = coord;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            entry_reg <= word_next;
        end
    end

    assign chain[0] = entry_reg;

    // Divide steps
    for (genvar i = 0; i < gckp_pkg::DVD_W; i++) begin : g_step
        gckp_div_step u_step (
            .aclk     (aclk),
            .adv      (adv),
            .cfg      (cfg),
            .din      (chain[i]),
            .dout_reg (chain[i+1])
        );
    end

    // Snapped coordinate: (2c + s - r) / 2, r the floored remainder; raw coordinate if snap is off or side is 0
    always_comb begin
        dvs     = {cfg.side, 1'b0};
        rmd     = chain[gckp_pkg::DVD_W].neg
                ? dvs - {{(gckp_pkg::DVS_W-1){1'b0}}, 1'b1} - chain[gckp_pkg::DVD_W].rem
                : chain[gckp_pkg::DVD_W].rem;
        snap_on = cfg.snap && (cfg.side != '0);
        sum     = $signed({{2{chain[gckp_pkg::DVD_W].coord[gckp_pkg::COORD_W-1]}},
                           chain[gckp_pkg::DVD_W].coord, 1'b0})
                + $signed({4'b0000, cfg.side})
                - $signed({3'b000, rmd});
        snap_next = snap_on ? sum[gckp_pkg::SNAP_W:1]
                            : {{2{chain[gckp_pkg::DVD_W].coord[gckp_pkg::COORD_W-1]}},
                               chain[gckp_pkg::DVD_W].coord};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            snap_reg <= snap_next;
        end
    end

    // Truncate magnitude, clamp, add the sign digit
    always_comb begin
        neg        = snap_reg[gckp_pkg::SNAP_W-1];
        mag        = neg ? -snap_reg : snap_reg;
        shifted    = mag >> FRAC_BITS;
        sat_next   = shifted > {{(gckp_pkg::SNAP_W-gckp_pkg::CLAMP_W){1'b0}},
                                gckp_pkg::MAG_LIMIT};
        clamped    = sat_next ? gckp_pkg::MAG_LIMIT : shifted[gckp_pkg::CLAMP_W-1:0];
        digit_next = {1'b0, clamped} + (neg ? gckp_pkg::SIGN_DIGIT : '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            digit_reg <= digit_next;
            sat_reg   <= sat_next;
        end
    end

endmodule

// ===== src/gckp_merge.sv =====
// Merge stage: packs the three axis digits into the decimal key.
// Depends on gckp_pkg.
module gckp_merge (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic [gckp_pkg::DIGIT_W-1:0]  dig_x,
    input  logic [gckp_pkg::DIGIT_W-1:0]  dig_y,
    input  logic [gckp_pkg::DIGIT_W-1:0]  dig_z,
    input  logic [2:0]                    sats,
    output gckp_pkg::key_word_t           key_reg
);

    logic [gckp_pkg::XY_W-1:0]    xy_next;
    logic [gckp_pkg::XY_W-1:0]    xy_reg;
    logic [gckp_pkg::DIGIT_W-1:0] z_reg;
    logic                         sat_reg;
    logic [gckp_pkg::KEY_W-1:0]   hi_part;
    logic [gckp_pkg::KEY_W-1:0]   lo_part;
    gckp_pkg::key_word_t          key_next;

    // x * 10^6 + y
    assign xy_next = gckp_pkg::XY_W'(dig_x * gckp_pkg::AXIS_SCALE)
                   + {{(gckp_pkg::XY_W-gckp_pkg::DIGIT_W){1'b0}}, dig_y};

    always_ff @(posedge aclk) begin
        if (adv) begin
            xy_reg  <= xy_next;
            z_reg   <= dig_z;
            sat_reg <= |sats;
        end
    end

    // xy * 10^6 + z, in two half-width products
    always_comb begin
        hi_part = gckp_pkg::KEY_W'(xy_reg[gckp_pkg::XY_W-1:gckp_pkg::XY_SPLIT]
                                   * gckp_pkg::AXIS_SCALE) << gckp_pkg::XY_SPLIT;
        lo_part = gckp_pkg::KEY_W'(xy_reg[gckp_pkg::XY_SPLIT-1:0] * gckp_pkg::AXIS_SCALE);
        key_next.cell_key  = hi_part + lo_part
                           + {{(gckp_pkg::KEY_W-gckp_pkg::DIGIT_W){1'b0}}, z_reg};
        key_next.saturated = sat_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            key_reg <= key_next;
        end
    end

endmodule

// ===== src/grid_cell_key_pack.sv =====
// Top level of the grid cell key packer: config registers, three axis lanes, merge.
// Depends on gckp_pkg, gckp_lane and gckp_merge.
//
//   channel   ports                       word
//   input     s_valid s_ready s_data      point_t (pos_x, pos_y, pos_z)
//   result    m_valid m_ready m_data      key_word_t (cell_key, saturated)
//   config    cfg_we cfg_index cfg_wdata  0: snap_enable, 1: side_length
//
// One word per cycle unless a result word waits untaken; the TOTAL_LAT stages are the 33 steps
// of the per-axis floor modulo plus entry, snap, digit and two merge stages.
// The whole pipeline advances together; it holds when the result is not taken.
// Reset (sync, aresetn low) clears the valids and snap, sets side to SIDE_RESET.
module grid_cell_key_pack #(
    parameter int FRAC_BITS = gckp_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  gckp_pkg::point_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output gckp_pkg::key_word_t                 m_data,
    input  logic                                cfg_we,
    input  logic [gckp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gckp_pkg::SIDE_W-1:0]         cfg_wdata
);

    logic                          adv;
    logic [gckp_pkg::TOTAL_LAT-1:0] vld_reg;
    logic [gckp_pkg::TOTAL_LAT-1:0] vld_next;
    gckp_pkg::grid_cfg_t           cfg_reg;
    gckp_pkg::grid_cfg_t           cfg_next;
    logic [gckp_pkg::DIGIT_W-1:0]  dig_x;
    logic [gckp_pkg::DIGIT_W-1:0]  dig_y;
    logic [gckp_pkg::DIGIT_W-1:0]  dig_z;
    logic [2:0]                    sats;

    // Advance the pipeline unless the output word is stalled
    assign adv     = !vld_reg[gckp_pkg::TOTAL_LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[gckp_pkg::TOTAL_LAT-1];

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (gckp_pkg::cfg_reg_t'(cfg_index))
                gckp_pkg::REG_SNAP_ENABLE: cfg_next.snap = cfg_wdata[0];
                gckp_pkg::REG_SIDE_LENGTH: cfg_next.side = cfg_wdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    assign vld_next = {vld_reg[gckp_pkg::TOTAL_LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.snap <= 1'b0;
            cfg_reg.side <= gckp_pkg::SIDE_RESET;
            vld_reg      <= '0;
        end else begin
            cfg_reg <= cfg_next;
            if (adv) begin
                vld_reg <= vld_next;
            end
        end
    end

    gckp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .aclk (aclk), .adv (adv), .cfg (cfg_reg), .coord (s_data.pos_x),
        .digit_reg (dig_x), .sat_reg (sats[2])
    );

    gckp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .aclk (aclk), .adv (adv), .cfg (cfg_reg), .coord (s_data.pos_y),
        .digit_reg (dig_y), .sat_reg (sats[1])
    );

    gckp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .aclk (aclk), .adv (adv), .cfg (cfg_reg), .coord (s_data.pos_z),
        .digit_reg (dig_z), .sat_reg (sats[0])
    );

    gckp_merge u_merge (
        .aclk    (aclk),
        .adv     (adv),
        .dig_x   (dig_x),
        .dig_y   (dig_y),
        .dig_z   (dig_z),
        .sats    (sats),
        .key_reg (m_data)
    );

endmodule

// ===== tb/gckp_checker.sv =====
// Checker for the grid cell key packer: predicts keys from accepted points and
// compares them with result words. Depends on gckp_pkg.
`timescale 1ns / 1ps

module gckp_checker #(
    parameter int FRAC_BITS = gckp_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  gckp_pkg::point_t               s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  gckp_pkg::key_word_t            m_data,
    input  logic                           cfg_we,
    input  logic [gckp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gckp_pkg::SIDE_W-1:0]    cfg_wdata,
    output int                             fail_count,
    output int                             keys_pending
);

    logic                        grid_snap;
    logic [gckp_pkg::SIDE_W-1:0] grid_side;
    gckp_pkg::key_word_t         key_queue[$];

    assign keys_pending = key_queue.size();

    // Snap one axis, cut to integer magnitude, clamp and add the sign digit
    function automatic longint axis_key_digits(
        input logic signed [gckp_pkg::COORD_W-1:0] coord, inout logic sat);
        longint c;
        longint s;
        longint n;
        longint q;
        longint mag;
        logic   neg;
        c = longint'(coord);
        s = longint'({1'b0, grid_side});
        if (grid_snap && s != 0) begin
            n = 2 * c - s;
            q = n / (2 * s);
            if ((n % (2 * s)) != 0 && n < 0) q = q - 1;
            c = (q + 1) * s;
        end
        neg = c < 0;
        mag = (neg ? -c : c) >>> FRAC_BITS;
        if (mag > 99999) begin
            mag = 99999;
            sat = 1'b1;
        end
        return mag + (neg ? 100000 : 0);
    endfunction

    function automatic gckp_pkg::key_word_t pack_cell_key(input gckp_pkg::point_t pt);
        gckp_pkg::key_word_t kw;
        logic                sat;
        longint              dx;
        longint              dy;
        longint              dz;
        sat = 1'b0;
        dx = axis_key_digits(pt.pos_x, sat);
        dy = axis_key_digits(pt.pos_y, sat);
        dz = axis_key_digits(pt.pos_z, sat);
        kw.cell_key  = gckp_pkg::KEY_W'(dz + dy * 64'd1000000 + dx * 64'd1000000000000);
        kw.saturated = sat;
        return kw;
    endfunction

    // Track registers, queue predictions and compare result words
    always @(posedge aclk) begin
        gckp_pkg::key_word_t want;
        if (!aresetn) begin
            grid_snap  <= 1'b0;
            grid_side  <= gckp_pkg::SIDE_RESET;
            fail_count <= 0;
            key_queue.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == gckp_pkg::REG_SNAP_ENABLE) grid_snap <= cfg_wdata[0];
                else if (cfg_index == gckp_pkg::REG_SIDE_LENGTH) grid_side <= cfg_wdata;
            end
            if (s_valid && s_ready) key_queue.push_back(pack_cell_key(s_data));
            if (m_valid && m_ready) begin
                if (key_queue.size() == 0) begin
                    $display("%0t: unexpected word key=%0d sat=%0b", $time,
                             m_data.cell_key, m_data.saturated);
                    fail_count <= fail_count + 1;
                end else begin
                    want = key_queue.pop_front();
                    if (want.cell_key !== m_data.cell_key) begin
                        $display("%0t: cell_key expected %0d actual %0d", $time,
                                 want.cell_key, m_data.cell_key);
                        fail_count <= fail_count + 1;
                    end else if (want.saturated !== m_data.saturated) begin
                        $display("%0t: saturated expected %0b actual %0b", $time,
                                 want.saturated, m_data.saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_grid_cell_key_pack.sv =====
// Testbench top for the grid cell key packer: drives points and register
// writes, stalls the result side. Depends on gckp_pkg, gckp_checker and the block.
`timescale 1ns / 1ps

module tb_grid_cell_key_pack;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    gckp_pkg::point_t               s_data;
    logic                           m_valid;
    logic                           m_ready;
    gckp_pkg::key_word_t            m_data;
    logic                           cfg_we;
    logic [gckp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gckp_pkg::SIDE_W-1:0]    cfg_wdata;
    int                             fail_count;
    int                             keys_pending;
    logic                           stall_on;

    grid_cell_key_pack i_dut (.*);

    gckp_checker i_check (.*);

    initial begin
        aclk = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = gckp_pkg::REG_SNAP_ENABLE;
        cfg_wdata = '0;
        aresetn = 1'b0;
        stall_on = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: alternate stall-free stretches with randomly stalled ones
    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
        m_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // Random coordinate, weighted toward small magnitudes and edges
    function automatic logic [gckp_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            3: return ($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, 8191));
            4: return ($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(409000000, 409700000));
            default: return ($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, 1 << 22));
        endcase
    endfunction

    // Write one register, then deassert the write enable
    task automatic write_reg(input gckp_pkg::cfg_reg_t idx,
                             input logic [gckp_pkg::SIDE_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Present one word and hold it until accepted
    task automatic send_point(input logic [gckp_pkg::COORD_W-1:0] x,
                              input logic [gckp_pkg::COORD_W-1:0] y,
                              input logic [gckp_pkg::COORD_W-1:0] z);
        s_valid <= 1'b1;
        s_data <= '{pos_x: x, pos_y: y, pos_z: z};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Send a burst-shaped run of random words, then drop valid
    task automatic send_random(input int count);
        int burst;
        int gap;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst = $urandom_range(1, 24);
            end
            send_point(pick_coord(), pick_coord(), pick_coord());
            burst--;
        end
        s_valid <= 1'b0;
    endtask

    // Wait for all keys plus the pipeline depth before touching registers
    task automatic drain();
        while (keys_pending != 0) @(posedge aclk);
        repeat (gckp_pkg::TOTAL_LAT + 4) @(posedge aclk);
    endtask

    initial begin
        logic [gckp_pkg::SIDE_W-1:0] sides[6];
        sides = '{31'd4096, 31'd1, 31'h7fff_ffff, 31'd2048, 31'd12288, 31'd0};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: raw packing at reset settings, edges and negative below one
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_point(-32'sd4095, 32'd4095, -32'sd4096);
        send_point(32'd409599999, -32'sd409599999, 32'd409600000);
        send_point(32'd409604095, -32'sd409604096, 32'hffff_f000);
        s_valid <= 1'b0;
        drain();
        write_reg(gckp_pkg::REG_SNAP_ENABLE, 31'd1);
        send_point(32'd2048, 32'd2047, -32'sd2048);
        send_point(-32'sd2049, 32'h8000_0000, 32'h7fff_ffff);
        send_point(32'd6144, -32'sd6144, 32'd1);
        s_valid <= 1'b0;

        // Random phases across side lengths, with and without snapping
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            write_reg(gckp_pkg::REG_SIDE_LENGTH,
                      ph < 6 ? sides[ph]
                             : gckp_pkg::SIDE_W'($urandom_range(1, 1 << 20)));
            write_reg(gckp_pkg::REG_SNAP_ENABLE,
                      (ph != 3 && ph != 9) ? 31'd1 : 31'd0);
            send_random(86);
        end
        drain();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
src/gckp_pkg.sv
src/gckp_div_step.sv
src/gckp_lane.sv
src/gckp_merge.sv
src/grid_cell_key_pack.sv
tb/gckp_checker.sv
tb/tb_grid_cell_key_pack.sv
